### rtl/core/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// tsfs_pkg
// Shared types for the thread slot scheduler: operation and status codes,
// command and result words, controller states.
// ----------------------------------------------------------------------------
package tsfs_pkg;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_YIELD = 2'd1,
        OP_SCHED = 2'd2,
        OP_EXIT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_NOT_VALID = 3'd3,
        ST_EXITED    = 3'd4
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [5:0] target;
    } t_sched_in;

    typedef struct packed {
        t_status    status;
        logic [3:0] result_id;
        logic [3:0] running_id;
        logic [4:0] queue_count;
    } t_sched_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_UNLINK,
        S_APPEND
    } t_state;

endpackage

### rtl/core/tsfs_link_ram.sv
// ----------------------------------------------------------------------------
// tsfs_link_ram
// Link memory: one write port, one clear port, one registered read port.
// A per-entry valid bit, cleared at reset and by the clear port, marks entries never written.
// ----------------------------------------------------------------------------
module tsfs_link_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [$bits(logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)*3+WIDTH+1:0])-1:0] i_req,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_rvalid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [WIDTH-1:0] wdata;
        logic             clr;
        logic [AW-1:0]    caddr;
        logic [AW-1:0]    raddr;
    } t_link_req;

    t_link_req        req;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld, n_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;

    assign req = t_link_req'(i_req);

    always_ff @(posedge i_clk) begin
        if (req.we) begin
            r_mem[req.waddr] <= req.wdata;
        end
        r_rdata <= r_mem[req.raddr];
    end

    // write wins over a clear of the same entry
    always_comb begin
        n_vld = r_vld;
        if (req.clr) begin
            n_vld[req.caddr] = 1'b0;
        end
        if (req.we) begin
            n_vld[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_rvld <= r_vld[req.raddr];
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvld;

endmodule

### rtl/core/thread_slot_fifo_scheduler.sv
// ----------------------------------------------------------------------------
// thread_slot_fifo_scheduler
// Thread slot scheduler with a round-robin spawn search and a FIFO ready
// queue kept as a doubly linked list in two link memories.
// ----------------------------------------------------------------------------
// One operation at a time: a command word is taken when start is high and
// busy is low, and its result word appears on o_result with o_done high for
// a single cycle, in the first cycle that busy is low again; the receiver
// cannot stall it. Errors, halted operations, a yield to the running slot and
// a sched with an empty queue finish in decode; exit goes through decode and
// unlink (decode only, when the last thread exits and the block halts); other
// yields and scheds go through decode, unlink from the link memories and
// append of the old running slot. Spawn goes through decode and then the
// free-slot search, which looks at one slot per cycle starting after the last
// slot spawned. Each link update is one read-modify-write pass through the
// prev and next link memories.
// ----------------------------------------------------------------------------
module thread_slot_fifo_scheduler #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  tsfs_pkg::t_sched_in    i_cmd,
    output logic                   busy,
    output logic                   o_done,
    output tsfs_pkg::t_sched_out   o_result
);

    import tsfs_pkg::*;

    localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int LW = SW + 1;
    localparam int CW = $clog2(THREAD_SLOTS + 1);
    localparam int TW = 7;

    localparam logic [LW-1:0]           LNONE     = {1'b1, {SW{1'b0}}};
    localparam logic [SW-1:0]           LAST_ID   = SW'(THREAD_SLOTS - 1);
    localparam logic [CW-1:0]           SLOTS_C   = CW'(THREAD_SLOTS);
    localparam logic [CW-1:0]           SCAN_LAST = CW'(THREAD_SLOTS - 1);
    localparam logic [TW-1:0]           SLOTS_T   = TW'(THREAD_SLOTS);
    localparam logic [THREAD_SLOTS-1:0] VALID_RST = THREAD_SLOTS'(1);

    typedef struct packed {
        logic          we;
        logic [SW-1:0] waddr;
        logic [LW-1:0] wdata;
        logic          clr;
        logic [SW-1:0] caddr;
        logic [SW-1:0] raddr;
    } t_link_req;

    function automatic logic [3:0] id4(input logic [SW-1:0] id);
        logic [SW+3:0] w;
        w = {4'b0000, id};
        return w[3:0];
    endfunction

    function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'b00000, c};
        return w[4:0];
    endfunction

    // control state
    t_state                  r_state, n_state;
    logic [THREAD_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [LW-1:0]           r_head, n_head;
    logic [LW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_count, n_count;
    logic [SW-1:0]           r_cur, n_cur;
    logic [SW-1:0]           r_last, n_last;
    logic                    r_halted, n_halted;
    logic                    r_done, n_done;

    // working registers
    t_op                     r_op, n_op;
    logic [5:0]              r_target, n_target;
    logic [SW-1:0]           r_tgt, n_tgt;
    logic [SW-1:0]           r_old, n_old;
    logic                    r_requeue, n_requeue;
    logic [SW-1:0]           r_scan, n_scan;
    logic [CW-1:0]           r_scan_cnt, n_scan_cnt;
    t_sched_out              r_res, n_res;

    t_link_req               prev_req, next_req;
    logic [LW-1:0]           prev_rdata, next_rdata;
    logic                    prev_rvalid, next_rvalid;
    logic [LW-1:0]           lp, ln;

    logic [SW-1:0]           tid;
    logic                    tgt_in_range;
    logic                    head_none;
    logic                    dec_scan;
    logic                    dec_link;
    logic [SW-1:0]           dec_tgt;
    logic                    scan_free;
    logic                    scan_end;

    t_status                 fin_status;
    logic [SW-1:0]           fin_rid;

    tsfs_link_ram #(
        .DEPTH (THREAD_SLOTS),
        .WIDTH (LW)
    ) u_prev_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (prev_req),
        .o_rdata  (prev_rdata),
        .o_rvalid (prev_rvalid)
    );

    tsfs_link_ram #(
        .DEPTH (THREAD_SLOTS),
        .WIDTH (LW)
    ) u_next_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (next_req),
        .o_rdata  (next_rdata),
        .o_rvalid (next_rvalid)
    );

    // decode helpers
    assign tid          = r_target[SW-1:0];
    assign tgt_in_range = {1'b0, r_target} < SLOTS_T;
    assign head_none    = r_head[SW];
    assign dec_scan     = !r_halted && (r_op == OP_SPAWN);
    assign dec_link     = !r_halted && (
                              ((r_op == OP_YIELD) && tgt_in_range && r_slot_valid[tid]
                                                  && (tid != r_cur))
                           || ((r_op == OP_SCHED) && !head_none)
                           || ((r_op == OP_EXIT)  && !head_none));
    assign dec_tgt      = (r_op == OP_YIELD) ? tid : r_head[SW-1:0];
    assign scan_free    = !r_slot_valid[r_scan];
    assign scan_end     = scan_free || (r_scan_cnt == SCAN_LAST);

    // entries never written, or cleared, read as no link
    assign lp = prev_rvalid ? prev_rdata : LNONE;
    assign ln = next_rvalid ? next_rdata : LNONE;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (dec_scan) begin
                    n_state = S_SCAN;
                end else if (dec_link) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_UNLINK: begin
                n_state = r_requeue ? S_APPEND : S_IDLE;
            end
            S_APPEND: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and link memory requests
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_cur        = r_cur;
        n_last       = r_last;
        n_halted     = r_halted;
        n_op         = r_op;
        n_target     = r_target;
        n_tgt        = r_tgt;
        n_old        = r_old;
        n_requeue    = r_requeue;
        n_scan       = r_scan;
        n_scan_cnt   = r_scan_cnt;
        n_res        = r_res;
        n_done       = 1'b0;
        fin_status   = ST_OK;
        fin_rid      = '0;

        prev_req       = '0;
        next_req       = '0;
        prev_req.raddr = dec_tgt;
        next_req.raddr = dec_tgt;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_cmd.operation;
                    n_target = i_cmd.target;
                end
            end

            S_DECODE: begin
                n_tgt = dec_tgt;
                if (r_halted) begin
                    n_done     = 1'b1;
                    fin_status = ST_EXITED;
                end else begin
                    unique case (r_op)
                        OP_SPAWN: begin
                            n_scan     = (r_last == LAST_ID) ? '0 : r_last + SW'(1);
                            n_scan_cnt = '0;
                        end
                        OP_YIELD: begin
                            n_requeue = 1'b1;
                            priority if (!tgt_in_range) begin
                                n_done     = 1'b1;
                                fin_status = ST_BAD_ID;
                            end else if (!r_slot_valid[tid]) begin
                                n_done     = 1'b1;
                                fin_status = ST_NOT_VALID;
                            end else if (tid == r_cur) begin
                                n_done  = 1'b1;
                                fin_rid = r_cur;
                            end
                        end
                        OP_SCHED: begin
                            n_requeue = 1'b1;
                            if (head_none) begin
                                n_done  = 1'b1;
                                fin_rid = r_cur;
                            end
                        end
                        OP_EXIT: begin
                            n_requeue           = 1'b0;
                            n_slot_valid[r_cur] = 1'b0;
                            if (head_none) begin
                                n_halted   = 1'b1;
                                n_done     = 1'b1;
                                fin_status = ST_EXITED;
                            end
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                priority if (scan_free) begin
                    n_slot_valid[r_scan] = 1'b1;
                    n_last               = r_scan;
                    // append the new slot at the tail
                    prev_req.we    = 1'b1;
                    prev_req.waddr = r_scan;
                    prev_req.wdata = r_tail;
                    next_req.clr   = 1'b1;
                    next_req.caddr = r_scan;
                    if (r_tail[SW]) begin
                        n_head = {1'b0, r_scan};
                    end else begin
                        next_req.we    = 1'b1;
                        next_req.waddr = r_tail[SW-1:0];
                        next_req.wdata = {1'b0, r_scan};
                    end
                    n_tail  = {1'b0, r_scan};
                    n_count = r_count + CW'(1);
                    n_done  = 1'b1;
                    fin_rid = r_scan;
                end else if (scan_end) begin
                    n_done     = 1'b1;
                    fin_status = ST_NO_FREE;
                end else begin
                    n_scan     = (r_scan == LAST_ID) ? '0 : r_scan + SW'(1);
                    n_scan_cnt = r_scan_cnt + CW'(1);
                end
            end

            S_UNLINK: begin
                n_old = r_cur;
                n_cur = r_tgt;
                // a slot with no predecessor that is not the head is not queued
                if (!((r_head != {1'b0, r_tgt}) && lp[SW])) begin
                    if (lp[SW]) begin
                        n_head = ln;
                    end else begin
                        next_req.we    = 1'b1;
                        next_req.waddr = lp[SW-1:0];
                        next_req.wdata = ln;
                    end
                    if (ln[SW]) begin
                        n_tail = lp;
                    end else begin
                        prev_req.we    = 1'b1;
                        prev_req.waddr = ln[SW-1:0];
                        prev_req.wdata = lp;
                    end
                    prev_req.clr   = 1'b1;
                    prev_req.caddr = r_tgt;
                    next_req.clr   = 1'b1;
                    next_req.caddr = r_tgt;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end
                if (!r_requeue) begin
                    n_done  = 1'b1;
                    fin_rid = r_cur;
                end
            end

            S_APPEND: begin
                prev_req.we    = 1'b1;
                prev_req.waddr = r_old;
                prev_req.wdata = r_tail;
                next_req.clr   = 1'b1;
                next_req.caddr = r_old;
                if (r_tail[SW]) begin
                    n_head = {1'b0, r_old};
                end else begin
                    next_req.we    = 1'b1;
                    next_req.waddr = r_tail[SW-1:0];
                    next_req.wdata = {1'b0, r_old};
                end
                n_tail  = {1'b0, r_old};
                n_count = r_count + CW'(1);
                n_done  = 1'b1;
                fin_rid = r_old;
            end

            default: begin
                n_done = 1'b0;
            end
        endcase

        if (n_done) begin
            n_res.status      = fin_status;
            n_res.result_id   = id4(fin_rid);
            n_res.running_id  = id4(n_cur);
            n_res.queue_count = cnt5(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= VALID_RST;
            r_head       <= LNONE;
            r_tail       <= LNONE;
            r_count      <= '0;
            r_cur        <= '0;
            r_last       <= '0;
            r_halted     <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_cur        <= n_cur;
            r_last       <= n_last;
            r_halted     <= n_halted;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_target   <= n_target;
        r_tgt      <= n_tgt;
        r_old      <= n_old;
        r_requeue  <= n_requeue;
        r_scan     <= n_scan;
        r_scan_cnt <= n_scan_cnt;
        r_res      <= n_res;
    end

    // checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("ready queue count above slot count");

    a_run_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_halted) |-> r_slot_valid[r_cur])
        else $error("running slot is not valid");

    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("operation finished without a result word");

    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_count == '0 && head_none))
        else $error("halted with threads still queued");

endmodule
